@@ rtl/core/psz_pkg.sv @@
// Shared types and constants for the point splat z-buffer.
`default_nettype none
package psz_pkg;
    localparam logic [1:0] FUNC_CLEAR   = 2'd0;
    localparam logic [1:0] FUNC_SPLAT   = 2'd1;
    localparam logic [1:0] FUNC_READ    = 2'd2;
    localparam logic [1:0] FUNC_IGNORED = 2'd3;

    localparam int unsigned REG_COS_YAW     = 0;
    localparam int unsigned REG_SIN_YAW     = 1;
    localparam int unsigned REG_COS_PITCH   = 2;
    localparam int unsigned REG_SIN_PITCH   = 3;
    localparam int unsigned REG_CENTER_X    = 4;
    localparam int unsigned REG_CENTER_Y    = 5;
    localparam int unsigned REG_CENTER_Z    = 6;
    localparam int unsigned REG_PIXEL_SCALE = 7;

    localparam logic [7:0]  WRITTEN_ALPHA = 8'd238;
    localparam logic [31:0] DEPTH_EMPTY   = 32'h8000_0000;

    // Work handed from the front end to the back end
    typedef struct packed {
        logic [1:0]         func;
        logic signed [15:0] col;
        logic signed [15:0] row;
        logic signed [31:0] depth;
        logic [23:0]        rgb;
    } psz_cmd_t;
endpackage
`default_nettype wire

@@ rtl/core/point_splat_zbuffer.sv @@
// Top level of the point splat z-buffer.
//  channel | direction | handshake        | payload
//  s_      | in        | s_valid/s_ready  | func, point, color, read position
//  m_      | out       | m_valid/m_ready  | screen position, depth, count, pixel
//  cfg     | in        | cfg_we           | cfg_index, cfg_data
// A splat runs its projection on the front end's shared multiplier, then nine
// read/compare/write steps on the single pixel RAM port in the back end.
// Reset and a clear item sweep the RAM, one pixel a cycle, over all SCREEN_COLS*SCREEN_ROWS
// pixels (307200 by default).
// Front and back each stall on their own; one command waits between them.
`default_nettype none
module point_splat_zbuffer #(
    parameter int SCREEN_COLS = 640,
    parameter int SCREEN_ROWS = 480
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [23:0] s_point_x,
    input  wire logic [23:0] s_point_y,
    input  wire logic [23:0] s_point_z,
    input  wire logic [7:0]  s_color_red,
    input  wire logic [7:0]  s_color_green,
    input  wire logic [7:0]  s_color_blue,
    input  wire logic [11:0] s_read_col,
    input  wire logic [11:0] s_read_row,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_screen_col,
    output logic [15:0]      m_screen_row,
    output logic [31:0]      m_view_depth,
    output logic [3:0]       m_pixels_written,
    output logic [7:0]       m_pixel_red,
    output logic [7:0]       m_pixel_green,
    output logic [7:0]       m_pixel_blue,
    output logic [7:0]       m_pixel_alpha
);
    import psz_pkg::*;

    logic     cv, cr;
    psz_cmd_t cmd;

    psz_front #(.SCREEN_COLS(SCREEN_COLS), .SCREEN_ROWS(SCREEN_ROWS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
        .in_valid(s_valid), .in_ready(s_ready), .in_func(s_func),
        .in_x(s_point_x), .in_y(s_point_y), .in_z(s_point_z),
        .in_rgb({s_color_red, s_color_green, s_color_blue}),
        .in_col(s_read_col), .in_row(s_read_row),
        .cmd_valid(cv), .cmd_ready(cr), .cmd(cmd)
    );

    psz_back #(.SCREEN_COLS(SCREEN_COLS), .SCREEN_ROWS(SCREEN_ROWS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(cv), .cmd_ready(cr), .cmd(cmd),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_screen_col(m_screen_col), .m_screen_row(m_screen_row),
        .m_view_depth(m_view_depth), .m_pixels_written(m_pixels_written),
        .m_pixel_red(m_pixel_red), .m_pixel_green(m_pixel_green),
        .m_pixel_blue(m_pixel_blue), .m_pixel_alpha(m_pixel_alpha)
    );
endmodule
`default_nettype wire

@@ rtl/core/psz_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module psz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

@@ rtl/core/psz_front.sv @@
// Front end: projects points through a shared-multiplier sequence.
`default_nettype none
module psz_front #(
    parameter int SCREEN_COLS = 640,
    parameter int SCREEN_ROWS = 480
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [2:0]             cfg_idx,
    input  wire logic [31:0]            cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [1:0]             in_func,
    input  wire logic signed [23:0]     in_x,
    input  wire logic signed [23:0]     in_y,
    input  wire logic signed [23:0]     in_z,
    input  wire logic [23:0]            in_rgb,
    input  wire logic [11:0]            in_col,
    input  wire logic [11:0]            in_row,
    output logic                        cmd_valid,
    input  wire logic                   cmd_ready,
    output psz_pkg::psz_cmd_t           cmd
);
    import psz_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_OUT  = 3'd2;

    // Microcode steps of the projection
    localparam logic [3:0] K_LAST = 4'd10;

    logic signed [15:0] cy_reg, sy_reg, cp_reg, sp_reg;
    logic signed [23:0] cx_reg, cyc_reg, cz_reg;
    logic [31:0]        scale_reg;

    logic [2:0]         st_reg;
    logic [3:0]         k_reg;
    logic signed [24:0] dx_reg, dy_reg, dz_reg;
    logic signed [47:0] acc_reg;
    logic signed [41:0] rx_reg, rz_reg, ry_reg;
    logic signed [63:0] dep_reg;
    logic signed [79:0] pq_reg;
    logic [23:0]        rgb_reg;
    psz_cmd_t           cmd_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cy_reg <= 16'sd13043; sy_reg <= 16'sd9916;
            cp_reg <= 16'sd15091; sp_reg <= -16'sd6380;
            cx_reg <= '0; cyc_reg <= '0; cz_reg <= '0;
            scale_reg <= 32'd13526630;
        end else if (cfg_we) begin
            case (cfg_idx)
                3'(REG_COS_YAW):     cy_reg    <= cfg_data[15:0];
                3'(REG_SIN_YAW):     sy_reg    <= cfg_data[15:0];
                3'(REG_COS_PITCH):   cp_reg    <= cfg_data[15:0];
                3'(REG_SIN_PITCH):   sp_reg    <= cfg_data[15:0];
                3'(REG_CENTER_X):    cx_reg    <= cfg_data[23:0];
                3'(REG_CENTER_Y):    cyc_reg   <= cfg_data[23:0];
                3'(REG_CENTER_Z):    cz_reg    <= cfg_data[23:0];
                3'(REG_PIXEL_SCALE): scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Round a 14-bit fraction half away from zero
    function automatic logic signed [41:0] rnd14(input logic signed [47:0] v);
        logic signed [47:0] t;
        t = v[47] ? (v + 48'sd8191) : (v + 48'sd8192);
        return 42'(t >>> 14);
    endfunction

    function automatic logic signed [15:0] pix(input logic signed [79:0] v);
        logic signed [79:0] t;
        logic signed [55:0] q;
        t = v[79] ? (v + 80'sh7FFFFF) : (v + 80'sh800000);
        q = 56'(t >>> 24);
        if (q > 56'sd32767) return 16'sh7FFF;
        if (q < -56'sd32768) return 16'sh8000;
        return q[15:0];
    endfunction

    // Shared 42x17 multiplier operands per step; the wide scale product is done
    // as two 42x17 halves (scale split into low 16 and high 16 bits)
    logic signed [41:0] ma;
    logic signed [16:0] mb;
    logic signed [58:0] prod;
    always_comb begin
        ma = '0; mb = '0;
        case (k_reg)
            4'd0: begin ma = 42'(dx_reg); mb = 17'(cy_reg); end
            4'd1: begin ma = 42'(dz_reg); mb = 17'(sy_reg); end
            4'd2: begin ma = 42'(dz_reg); mb = 17'(cy_reg); end
            4'd3: begin ma = 42'(dx_reg); mb = -17'(sy_reg); end
            4'd4: begin ma = 42'(dy_reg); mb = 17'(cp_reg); end
            4'd5: begin ma = rz_reg;      mb = -17'(sp_reg); end
            4'd6: begin ma = 42'(dy_reg); mb = 17'(sp_reg); end
            4'd7: begin ma = rz_reg;      mb = 17'(cp_reg); end
            4'd8: begin ma = rx_reg; mb = 17'({1'b0, scale_reg[15:0]}); end
            4'd9: begin ma = rx_reg; mb = 17'({1'b0, scale_reg[31:16]}); end
            4'd10: begin ma = -ry_reg; mb = 17'({1'b0, scale_reg[15:0]}); end
            default: begin ma = -ry_reg; mb = 17'({1'b0, scale_reg[31:16]}); end
        endcase
        prod = 59'(ma) * 59'(mb);
    end

    // Depth saturated to 32 bits
    logic signed [31:0] dep_sat;
    always_comb begin
        if (dep_reg > 64'sh7FFFFFFF)
            dep_sat = 32'sh7FFFFFFF;
        else if (dep_reg < -64'sh80000000)
            dep_sat = 32'sh80000000;
        else
            dep_sat = dep_reg[31:0];
    end

    logic signed [79:0] colq0, rowq0;
    assign colq0 = 80'(SCREEN_COLS) <<< 23;
    assign rowq0 = 80'(SCREEN_ROWS) <<< 23;

    assign in_ready  = (st_reg == ST_IDLE);
    assign cmd_valid = (st_reg == ST_OUT);
    assign cmd       = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            k_reg  <= '0;
        end else begin
            case (st_reg)
                ST_IDLE: if (in_valid) begin
                    dx_reg <= 25'(in_x) - 25'(cx_reg);
                    dy_reg <= 25'(in_y) - 25'(cyc_reg);
                    dz_reg <= 25'(in_z) - 25'(cz_reg);
                    rgb_reg <= in_rgb;
                    k_reg <= '0;
                    acc_reg <= '0;
                    // Reads echo their position, everything else starts at zero
                    cmd_reg <= '{func:  in_func,
                                 col:   (in_func == FUNC_READ) ? 16'({4'd0, in_col}) : 16'd0,
                                 row:   (in_func == FUNC_READ) ? 16'({4'd0, in_row}) : 16'd0,
                                 depth: 32'd0,
                                 rgb:   24'd0};
                    if (in_func == FUNC_SPLAT) begin
                        st_reg <= ST_MUL;
                    end else begin
                        st_reg <= ST_OUT;
                    end
                end
                ST_MUL: begin
                    k_reg <= k_reg + 4'd1;
                    case (k_reg)
                        4'd0, 4'd2, 4'd4, 4'd6: acc_reg <= 48'(prod);
                        4'd1: rx_reg <= rnd14(acc_reg + 48'(prod));
                        4'd3: rz_reg <= rnd14(acc_reg + 48'(prod));
                        4'd5: ry_reg <= rnd14(acc_reg + 48'(prod));
                        4'd7: dep_reg <= 64'(rnd14(acc_reg + 48'(prod)));
                        4'd8, 4'd10: pq_reg <= 80'(prod);
                        4'd9: begin
                            cmd_reg.col <= pix(colq0 + pq_reg + (80'(prod) <<< 16));
                        end
                        default: begin
                            cmd_reg <= '{func:  cmd_reg.func,
                                         col:   cmd_reg.col,
                                         row:   pix(rowq0 + pq_reg + (80'(prod) <<< 16)),
                                         depth: dep_sat,
                                         rgb:   rgb_reg};
                        end
                    endcase
                    if (k_reg > K_LAST) st_reg <= ST_OUT;
                end
                ST_OUT: if (cmd_ready) st_reg <= ST_IDLE;
                default: st_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/psz_back.sv @@
// Back end: clear sweep, 3x3 depth-tested splat and pixel reads.
`default_nettype none
module psz_back #(
    parameter int SCREEN_COLS = 640,
    parameter int SCREEN_ROWS = 480
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire psz_pkg::psz_cmd_t  cmd,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [15:0]             m_screen_col,
    output logic [15:0]             m_screen_row,
    output logic [31:0]             m_view_depth,
    output logic [3:0]              m_pixels_written,
    output logic [7:0]              m_pixel_red,
    output logic [7:0]              m_pixel_green,
    output logic [7:0]              m_pixel_blue,
    output logic [7:0]              m_pixel_alpha
);
    import psz_pkg::*;

    localparam int PIX = SCREEN_COLS * SCREEN_ROWS;
    localparam int AW  = $clog2(PIX);

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_CHK   = 3'd3;
    localparam logic [2:0] ST_RDW   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]     st_reg;
    logic [AW-1:0]  clr_reg;
    logic           clr_item_reg;
    psz_cmd_t       c_reg;
    logic [3:0]     n_reg;
    logic [3:0]     cnt_reg;
    logic [AW-1:0]  addr_reg;
    logic           inb_reg;

    logic           we;
    logic [AW-1:0]  addr;
    logic [55:0]    wdata, rdata;

    psz_ram #(.WIDTH(56), .DEPTH(PIX)) u_ram (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    // Neighbor n of the splat: offsets -1..1 in row-major order
    logic [3:0]         nofs;
    logic signed [17:0] nx, ny;
    logic               nin;
    logic [AW-1:0]      naddr;
    always_comb begin
        // {row offset, column offset}, each 0..2
        case (n_reg)
            4'd0:    nofs = {2'd0, 2'd0};
            4'd1:    nofs = {2'd0, 2'd1};
            4'd2:    nofs = {2'd0, 2'd2};
            4'd3:    nofs = {2'd1, 2'd0};
            4'd4:    nofs = {2'd1, 2'd1};
            4'd5:    nofs = {2'd1, 2'd2};
            4'd6:    nofs = {2'd2, 2'd0};
            4'd7:    nofs = {2'd2, 2'd1};
            default: nofs = {2'd2, 2'd2};
        endcase
        nx = 18'(c_reg.col) + 18'(nofs[1:0]) - 18'sd1;
        ny = 18'(c_reg.row) + 18'(nofs[3:2]) - 18'sd1;
        nin = (nx >= 0) && (nx < 18'(SCREEN_COLS)) &&
              (ny >= 0) && (ny < 18'(SCREEN_ROWS));
        naddr = AW'(ny[12:0] * 13'(SCREEN_COLS) + 26'(nx[12:0]));
    end

    logic rd_in;
    assign rd_in = (c_reg.col < 16'(SCREEN_COLS)) && (c_reg.row < 16'(SCREEN_ROWS));

    logic rd_hit;
    assign rd_hit = $signed(c_reg.depth) > $signed(rdata[55:24]);

    // RAM port control
    always_comb begin
        we = 1'b0; addr = addr_reg; wdata = {c_reg.depth, c_reg.rgb};
        case (st_reg)
            ST_CLR: begin we = 1'b1; addr = clr_reg; wdata = {DEPTH_EMPTY, 24'd0}; end
            ST_RD:  addr = naddr;
            ST_CHK: we = inb_reg && rd_hit;
            default: ;
        endcase
    end

    assign cmd_ready = (st_reg == ST_IDLE);
    assign m_valid   = (st_reg == ST_OUT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_CLR;
            clr_reg      <= '0;
            clr_item_reg <= 1'b0;
        end else begin
            case (st_reg)
                ST_CLR: begin
                    if (clr_reg == AW'(PIX - 1)) begin
                        // A clear item answers; the sweep after reset does not
                        st_reg <= clr_item_reg ? ST_OUT : ST_IDLE;
                    end
                    clr_reg <= clr_reg + 1'b1;
                end
                ST_IDLE: if (cmd_valid) begin
                    c_reg <= cmd;
                    n_reg <= '0;
                    cnt_reg <= '0;
                    clr_reg <= '0;
                    clr_item_reg <= (cmd.func == FUNC_CLEAR);
                    case (cmd.func)
                        FUNC_CLEAR: st_reg <= ST_CLR;
                        FUNC_SPLAT: st_reg <= ST_RD;
                        FUNC_READ:  st_reg <= ST_RDW;
                        default:    st_reg <= ST_OUT;
                    endcase
                end
                ST_RD: begin
                    addr_reg <= naddr;
                    inb_reg  <= nin;
                    st_reg   <= ST_CHK;
                end
                ST_CHK: begin
                    // read data for addr_reg is now valid
                    if (inb_reg && rd_hit) cnt_reg <= cnt_reg + 4'd1;
                    n_reg <= n_reg + 4'd1;
                    st_reg <= (n_reg == 4'd8) ? ST_OUT : ST_RD;
                end
                ST_RDW: begin
                    addr_reg <= AW'(c_reg.row[11:0] * 13'(SCREEN_COLS) + 24'(c_reg.col[11:0]));
                    n_reg <= n_reg + 4'd1;
                    if (n_reg == 4'd2) st_reg <= ST_OUT;
                end
                ST_OUT: if (m_ready) st_reg <= ST_IDLE;
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    // Result fields from the held command, the splat count and the read data
    always_comb begin
        m_screen_col = '0; m_screen_row = '0; m_view_depth = '0;
        m_pixels_written = '0; m_pixel_red = '0; m_pixel_green = '0;
        m_pixel_blue = '0; m_pixel_alpha = '0;
        case (c_reg.func)
            FUNC_SPLAT: begin
                m_screen_col = c_reg.col; m_screen_row = c_reg.row;
                m_view_depth = c_reg.depth; m_pixels_written = cnt_reg;
            end
            FUNC_READ: begin
                m_screen_col = c_reg.col; m_screen_row = c_reg.row;
                if (rd_in) begin
                    m_view_depth = rdata[55:24];
                    m_pixel_red = rdata[23:16]; m_pixel_green = rdata[15:8];
                    m_pixel_blue = rdata[7:0];
                    m_pixel_alpha = (rdata[55:24] != DEPTH_EMPTY) ? WRITTEN_ALPHA : 8'd0;
                end else begin
                    m_view_depth = DEPTH_EMPTY;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/core/psz_checker.sv @@
// Port-level checks for the point splat z-buffer, bound to the top level.
`default_nettype none
module psz_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [3:0]  m_pixels_written,
    input wire logic [7:0]  m_pixel_alpha,
    input wire logic [31:0] m_view_depth
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_view_depth)) else $error("result changed");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_pixels_written <= 4'd9) else $error("count too big");
    a_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pixel_alpha == 8'd0 || m_pixel_alpha == 8'd238))
        else $error("bad alpha");
endmodule

bind point_splat_zbuffer psz_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_pixels_written(m_pixels_written), .m_pixel_alpha(m_pixel_alpha),
    .m_view_depth(m_view_depth)
);
`default_nettype wire
